[design/fqdk_pkg.sv]
// Shared types and codes for the FIFO queue with delete-by-key.
`timescale 1ns / 1ps

package fqdk_pkg;

  // Field widths of the item ports
  localparam int OP_W     = 2;
  localparam int IN_ID_W  = 16;
  localparam int IN_QTY_W = 16;
  localparam int STATUS_W = 2;
  localparam int OUT_CNT_W = 5;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ENQ = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ = 2'd1;
  localparam logic [OP_W-1:0] OP_DEL = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_ROTATE,
    S_FINISH
  } state_t;

  // Where the result id and quantity come from
  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_HEAD,
    SRC_CAP
  } src_t;

  typedef struct packed {
    logic                latch;
    logic                enq;
    logic                deq;
    logic                rot_start;
    logic                rot_step;
    logic                res_load;
    logic [STATUS_W-1:0] res_status;
    src_t                res_src;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            empty;
    logic            full;
    logic            last;
    logic            found;
  } sts_t;

endpackage

[design/fifo_queue_with_delete_by_key_unit.sv]
// Top level of the FIFO queue with delete-by-key.
//
// Holds up to DEPTH (id, quantity) entries in a row of register cells, cell 0 the head.
// Input item: operation, item_id, quantity on in_* with in_valid / in_stall.
// Result item: status, out_id, out_quantity, entry_count on out_* with out_valid / out_stall.
// An item is taken when valid is high and stall is low at a rising edge.
// Enqueue and dequeue: accepted in the idle state, executed in the exec state once the output
//   slot is free; the result then sits in the output register, and the block is idle again.
// Delete: the held entries rotate through the head cell, one per cycle, where the key is
//   compared; the first match is dropped, the rest go back to the tail in order.
//   An item goes through accept, start, one rotation step per held entry, and result.
// A delete on an empty queue and the unused operation code finish in exec like enqueue.
// A stalled result holds in the output register; the next item may still be accepted
// and worked up to the point of handing over its result, where it waits for the slot.
// Reset (rst_n low, synchronous) empties the queue and drops any pending result; cell
// contents are not cleared, only cells below the count are ever read.
// entry_count carries the low 5 bits of the count.
`timescale 1ns / 1ps

module fifo_queue_with_delete_by_key_unit #(
  parameter int DEPTH    = 16,
  parameter int ID_BITS  = 16,
  parameter int QTY_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [fqdk_pkg::OP_W-1:0]           in_operation,
  input  logic [fqdk_pkg::IN_ID_W-1:0]        in_item_id,
  input  logic [fqdk_pkg::IN_QTY_W-1:0]       in_quantity,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [fqdk_pkg::STATUS_W-1:0]       out_status,
  output logic [fqdk_pkg::IN_ID_W-1:0]        out_id,
  output logic [fqdk_pkg::IN_QTY_W-1:0]       out_quantity,
  output logic [fqdk_pkg::OUT_CNT_W-1:0]      out_entry_count
);

  localparam int CW = $clog2(DEPTH + 1);

  fqdk_pkg::cmd_t      cmd;
  fqdk_pkg::sts_t      sts;
  logic [ID_BITS-1:0]  req_id;
  logic [QTY_BITS-1:0] req_qty;
  logic [ID_BITS-1:0]  res_id;
  logic [QTY_BITS-1:0] res_qty;
  logic [CW-1:0]       res_count;

  // id and quantity are kept modulo 2^ID_BITS / 2^QTY_BITS
  assign req_id  = ID_BITS'({32'd0, in_item_id});
  assign req_qty = QTY_BITS'({32'd0, in_quantity});

  fqdk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  fqdk_dpath #(
    .DEPTH    (DEPTH),
    .ID_BITS  (ID_BITS),
    .QTY_BITS (QTY_BITS),
    .CW       (CW)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .req_op     (in_operation),
    .req_id     (req_id),
    .req_qty    (req_qty),
    .res_status (out_status),
    .res_id     (res_id),
    .res_qty    (res_qty),
    .res_count  (res_count)
  );

  assign out_id          = fqdk_pkg::IN_ID_W'({32'd0, res_id});
  assign out_quantity    = fqdk_pkg::IN_QTY_W'({32'd0, res_qty});
  assign out_entry_count = fqdk_pkg::OUT_CNT_W'({{fqdk_pkg::OUT_CNT_W{1'b0}}, res_count});

endmodule

[design/fqdk_ctrl.sv]
// Controller state machine of the FIFO queue with delete-by-key.
`timescale 1ns / 1ps

module fqdk_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  fqdk_pkg::sts_t  sts,
  output fqdk_pkg::cmd_t  cmd
);

  fqdk_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  assign slot_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign in_stall  = (state_r != fqdk_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fqdk_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.res_status = fqdk_pkg::ST_DONE;
    cmd.res_src    = fqdk_pkg::SRC_ZERO;
    case (state_r)
      fqdk_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = fqdk_pkg::S_EXEC;
        end
      end
      fqdk_pkg::S_EXEC: begin
        case (sts.op)
          fqdk_pkg::OP_ENQ: begin
            if (slot_free) begin
              cmd.enq        = !sts.full;
              cmd.res_load   = 1'b1;
              cmd.res_status = sts.full ? fqdk_pkg::ST_FULL : fqdk_pkg::ST_DONE;
              state_nxt      = fqdk_pkg::S_IDLE;
            end
          end
          fqdk_pkg::OP_DEQ: begin
            if (slot_free) begin
              cmd.deq        = !sts.empty;
              cmd.res_load   = 1'b1;
              cmd.res_status = sts.empty ? fqdk_pkg::ST_EMPTY : fqdk_pkg::ST_DONE;
              cmd.res_src    = sts.empty ? fqdk_pkg::SRC_ZERO : fqdk_pkg::SRC_HEAD;
              state_nxt      = fqdk_pkg::S_IDLE;
            end
          end
          fqdk_pkg::OP_DEL: begin
            if (!sts.empty) begin
              cmd.rot_start = 1'b1;
              state_nxt     = fqdk_pkg::S_ROTATE;
            end else if (slot_free) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = fqdk_pkg::ST_EMPTY;
              state_nxt      = fqdk_pkg::S_IDLE;
            end
          end
          default: begin
            // unused code: report the count, change nothing
            if (slot_free) begin
              cmd.res_load = 1'b1;
              state_nxt    = fqdk_pkg::S_IDLE;
            end
          end
        endcase
      end
      fqdk_pkg::S_ROTATE: begin
        cmd.rot_step = 1'b1;
        if (sts.last) begin
          state_nxt = fqdk_pkg::S_FINISH;
        end
      end
      fqdk_pkg::S_FINISH: begin
        if (slot_free) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = sts.found ? fqdk_pkg::ST_DONE : fqdk_pkg::ST_NOT_FOUND;
          cmd.res_src    = sts.found ? fqdk_pkg::SRC_CAP : fqdk_pkg::SRC_ZERO;
          state_nxt      = fqdk_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = fqdk_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule

[design/fqdk_dpath.sv]
// Datapath of the FIFO queue with delete-by-key: cell row, count and result register.
`timescale 1ns / 1ps

module fqdk_dpath #(
  parameter int DEPTH    = 16,
  parameter int ID_BITS  = 16,
  parameter int QTY_BITS = 16,
  parameter int CW       = $clog2(DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fqdk_pkg::cmd_t                    cmd,
  output fqdk_pkg::sts_t                    sts,
  input  logic [fqdk_pkg::OP_W-1:0]         req_op,
  input  logic [ID_BITS-1:0]                req_id,
  input  logic [QTY_BITS-1:0]               req_qty,
  output logic [fqdk_pkg::STATUS_W-1:0]     res_status,
  output logic [ID_BITS-1:0]                res_id,
  output logic [QTY_BITS-1:0]               res_qty,
  output logic [CW-1:0]                     res_count
);

  logic [ID_BITS-1:0]  cell_id_r  [DEPTH];
  logic [QTY_BITS-1:0] cell_qty_r [DEPTH];
  logic [ID_BITS-1:0]  cell_id_nxt  [DEPTH];
  logic [QTY_BITS-1:0] cell_qty_nxt [DEPTH];

  logic [fqdk_pkg::OP_W-1:0] op_r;
  logic [ID_BITS-1:0]        key_r;
  logic [QTY_BITS-1:0]       qty_r;
  logic [CW-1:0]             count_r, count_nxt;
  logic [CW-1:0]             rem_r;
  logic                      found_r;
  logic [ID_BITS-1:0]        cap_id_r;
  logic [QTY_BITS-1:0]       cap_qty_r;
  logic [fqdk_pkg::STATUS_W-1:0] res_status_r;
  logic [ID_BITS-1:0]        res_id_r;
  logic [QTY_BITS-1:0]       res_qty_r;
  logic [CW-1:0]             res_count_r;
  logic                      head_match;
  logic [CW-1:0]             tail_pos;

  // during a rotation the head is either dropped (first match) or goes back to the tail
  assign head_match = !found_r && (cell_id_r[0] == key_r);
  assign tail_pos   = count_r - CW'(1);

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam int NXT = (g < DEPTH - 1) ? g + 1 : g;
    always_comb begin
      cell_id_nxt[g]  = cell_id_r[g];
      cell_qty_nxt[g] = cell_qty_r[g];
      if (cmd.enq && (CW'(g) == count_r)) begin
        cell_id_nxt[g]  = key_r;
        cell_qty_nxt[g] = qty_r;
      end
      if (cmd.deq || cmd.rot_step) begin
        cell_id_nxt[g]  = cell_id_r[NXT];
        cell_qty_nxt[g] = cell_qty_r[NXT];
      end
      if (cmd.rot_step && !head_match && (CW'(g) == tail_pos)) begin
        cell_id_nxt[g]  = cell_id_r[0];
        cell_qty_nxt[g] = cell_qty_r[0];
      end
    end
    always_ff @(posedge clk) begin
      cell_id_r[g]  <= cell_id_nxt[g];
      cell_qty_r[g] <= cell_qty_nxt[g];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.enq) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.deq || (cmd.rot_step && head_match)) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rem_r   <= '0;
      found_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.rot_start) begin
        rem_r   <= count_r;
        found_r <= 1'b0;
      end else if (cmd.rot_step) begin
        rem_r <= rem_r - CW'(1);
        if (head_match) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= req_op;
      key_r <= req_id;
      qty_r <= req_qty;
    end
    if (cmd.rot_step && head_match) begin
      cap_id_r  <= cell_id_r[0];
      cap_qty_r <= cell_qty_r[0];
    end
    if (cmd.res_load) begin
      res_status_r <= cmd.res_status;
      res_count_r  <= count_nxt;
      case (cmd.res_src)
        fqdk_pkg::SRC_HEAD: begin
          res_id_r  <= cell_id_r[0];
          res_qty_r <= cell_qty_r[0];
        end
        fqdk_pkg::SRC_CAP: begin
          res_id_r  <= cap_id_r;
          res_qty_r <= cap_qty_r;
        end
        default: begin
          res_id_r  <= '0;
          res_qty_r <= '0;
        end
      endcase
    end
  end

  assign sts.op    = op_r;
  assign sts.empty = (count_r == '0);
  assign sts.full  = (count_r == CW'(DEPTH));
  assign sts.last  = (rem_r == CW'(1));
  assign sts.found = found_r;

  assign res_status = res_status_r;
  assign res_id     = res_id_r;
  assign res_qty    = res_qty_r;
  assign res_count  = res_count_r;

endmodule

[design/fqdk_checker.sv]
// Port-level checker for the FIFO queue with delete-by-key, bound to the top level.
`timescale 1ns / 1ps

module fqdk_checker #(
  parameter int DEPTH = 16
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [fqdk_pkg::STATUS_W-1:0]      out_status,
  input logic [fqdk_pkg::IN_ID_W-1:0]       out_id,
  input logic [fqdk_pkg::IN_QTY_W-1:0]      out_quantity,
  input logic [fqdk_pkg::OUT_CNT_W-1:0]     out_entry_count
);

  // a held result stays put: valid, entry count and id stay stable
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_entry_count) && $stable(out_id))
    else $error("result changed while stalled");

  // one item at a time: busy right after taking one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on back-to-back cycles");

  // an empty report carries no entry and a zero count
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == fqdk_pkg::ST_EMPTY) |->
      (out_entry_count == '0) && (out_id == '0) && (out_quantity == '0))
    else $error("empty status with entry data");

  // a full report only when the queue holds DEPTH entries
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == fqdk_pkg::ST_FULL) |->
      (out_entry_count == fqdk_pkg::OUT_CNT_W'(DEPTH)) && (out_id == '0))
    else $error("full status with wrong count");

endmodule

bind fifo_queue_with_delete_by_key_unit fqdk_checker #(.DEPTH(DEPTH)) u_fqdk_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_id          (out_id),
  .out_quantity    (out_quantity),
  .out_entry_count (out_entry_count)
);

[tb/sv/tb.sv]
// Self-checking testbench for the FIFO queue with delete-by-key.
`timescale 1ns / 1ps

module tb;

  localparam int QUEUE_DEPTH   = 16;
  localparam int ITEMS_RANDOM  = 450;
  localparam int RX_HOLD       = 64;    // long receiver hold-off, in cycles
  localparam int QUIET_LIMIT   = 2000;  // cycles without any handshake before giving up
  localparam int SETTLE_CYCLES = 8;     // tail after the last result
  localparam int REPORT_MAX    = 10;

  // Unused operation code: the block must leave the queue alone and report done
  localparam logic [fqdk_pkg::OP_W-1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [fqdk_pkg::IN_ID_W-1:0]  id;
    logic [fqdk_pkg::IN_QTY_W-1:0] qty;
  } entry_t;

  typedef struct packed {
    logic [fqdk_pkg::STATUS_W-1:0]  status;
    logic [fqdk_pkg::IN_ID_W-1:0]   id;
    logic [fqdk_pkg::IN_QTY_W-1:0]  qty;
    logic [fqdk_pkg::OUT_CNT_W-1:0] count;
  } result_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [fqdk_pkg::OP_W-1:0]      in_operation = OP_NONE;
  logic [fqdk_pkg::IN_ID_W-1:0]   in_item_id = '0;
  logic [fqdk_pkg::IN_QTY_W-1:0]  in_quantity = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [fqdk_pkg::STATUS_W-1:0]  out_status;
  logic [fqdk_pkg::IN_ID_W-1:0]   out_id;
  logic [fqdk_pkg::IN_QTY_W-1:0]  out_quantity;
  logic [fqdk_pkg::OUT_CNT_W-1:0] out_entry_count;

  // Predicted queue contents, head at index 0
  entry_t  held_entries[$];
  // Results still owed by the block, oldest first
  result_t expected_results[$];

  bit calm        = 1'b0;  // no idling on either side while set
  bit rx_hold_req = 1'b0;  // ask the receiver for one long hold-off
  int failures    = 0;
  int items_sent  = 0;
  int results_got = 0;
  int peak_fill   = 0;
  int quiet_cycles = 0;
  int status_seen[4];

  fifo_queue_with_delete_by_key_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_item_id     (in_item_id),
    .in_quantity    (in_quantity),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_id         (out_id),
    .out_quantity   (out_quantity),
    .out_entry_count(out_entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Queue predictor: applies one operation to the held entries and returns
  // the result the block owes for it.
  // ---------------------------------------------------------------------------
  function automatic result_t queue_apply(logic [fqdk_pkg::OP_W-1:0] op,
                                          logic [fqdk_pkg::IN_ID_W-1:0] key,
                                          logic [fqdk_pkg::IN_QTY_W-1:0] qty);
    result_t res;
    entry_t  ent;
    int      hit;
    res = '0;
    res.status = fqdk_pkg::ST_DONE;
    hit = -1;
    case (op)
      fqdk_pkg::OP_ENQ: begin
        if (held_entries.size() >= QUEUE_DEPTH) begin
          res.status = fqdk_pkg::ST_FULL;   // dropped, count unchanged
        end else begin
          ent.id  = key;
          ent.qty = qty;
          held_entries.push_back(ent);
        end
      end
      fqdk_pkg::OP_DEQ: begin
        if (held_entries.size() == 0) begin
          res.status = fqdk_pkg::ST_EMPTY;
        end else begin
          ent = held_entries.pop_front();
          res.id  = ent.id;
          res.qty = ent.qty;
        end
      end
      fqdk_pkg::OP_DEL: begin
        if (held_entries.size() == 0) begin
          res.status = fqdk_pkg::ST_EMPTY;
        end else begin
          // first match counted from the head wins
          for (int i = 0; i < held_entries.size(); i++) begin
            if (hit < 0 && held_entries[i].id == key) hit = i;
          end
          if (hit < 0) begin
            res.status = fqdk_pkg::ST_NOT_FOUND;
          end else begin
            res.id  = held_entries[hit].id;
            res.qty = held_entries[hit].qty;
            held_entries.delete(hit);
          end
        end
      end
      default: ;  // unused code: no change, done status
    endcase
    res.count = fqdk_pkg::OUT_CNT_W'(held_entries.size());
    if (held_entries.size() > peak_fill) peak_fill = held_entries.size();
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: offers one item, holds it until taken, then books its result.
  // Always entered and left on a rising edge.
  // ---------------------------------------------------------------------------
  task automatic send_item(logic [fqdk_pkg::OP_W-1:0] op,
                           logic [fqdk_pkg::IN_ID_W-1:0] key,
                           logic [fqdk_pkg::IN_QTY_W-1:0] qty);
    if (!calm && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_item_id   <= key;
    in_quantity  <= qty;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(queue_apply(op, key, qty));
    items_sent++;
  endtask

  // Sender pause: lower valid and wait for every owed result
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (expected_results.size() == 0);
    @(posedge clk);
  endtask

  // Ids half the time from a narrow set so duplicates and hits are common
  function automatic logic [fqdk_pkg::IN_ID_W-1:0] pick_id();
    if ($urandom_range(0, 1)) return fqdk_pkg::IN_ID_W'($urandom_range(0, 7));
    return fqdk_pkg::IN_ID_W'($urandom);
  endfunction

  function automatic logic [fqdk_pkg::IN_ID_W-1:0] pick_key();
    if (held_entries.size() != 0 && $urandom_range(0, 9) < 7)
      return held_entries[$urandom_range(0, held_entries.size() - 1)].id;
    return pick_id();
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver stall: random idling, or one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        out_stall <= 1'b1;
        repeat (RX_HOLD - 1) @(posedge clk);
        rx_hold_req = 1'b0;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 33);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every taken result against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_status, out_id, out_quantity, out_entry_count};
      results_got++;
      status_seen[out_status]++;
      if (expected_results.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("%0t: result with nothing owed: st=%0d id=%h qty=%h cnt=%0d",
                   $realtime, got.status, got.id, got.qty, got.count);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          failures++;
          if (failures <= REPORT_MAX)
            $display({"%0t: result %0d: exp st=%0d id=%h qty=%h cnt=%0d,",
                      " got st=%0d id=%h qty=%h cnt=%0d"},
                     $realtime, results_got, want.status, want.id, want.qty, want.count,
                     got.status, got.id, got.qty, got.count);
        end
      end
    end
  end

  // Watchdog: too long without any handshake on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles, %0d results owed",
               QUIET_LIMIT, expected_results.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Dequeue, delete and the unused code straight after reset
  task automatic test_empty_queue();
    send_item(fqdk_pkg::OP_DEQ, 16'h0000, 16'h0000);
    send_item(fqdk_pkg::OP_DEL, 16'h0000, 16'hFFFF);
    send_item(OP_NONE, 16'hFFFF, 16'hFFFF);
  endtask

  // Fill to the brim with extreme and repeated ids, then one enqueue too many
  task automatic test_fill_and_overflow();
    logic [fqdk_pkg::IN_ID_W-1:0]  key;
    logic [fqdk_pkg::IN_QTY_W-1:0] qty;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      key = fqdk_pkg::IN_ID_W'(i % 5);
      qty = fqdk_pkg::IN_QTY_W'(16'h1000 + i);
      if (i == 1) begin
        key = 16'hFFFF;
        qty = 16'hFFFF;
      end
      if (i == 0) qty = 16'h0000;
      if (i == QUEUE_DEPTH - 1) key = 16'h8001;  // unique id at the tail
      send_item(fqdk_pkg::OP_ENQ, key, qty);
    end
    send_item(fqdk_pkg::OP_ENQ, 16'h5555, 16'hAAAA);
  endtask

  // No match, first of several matches, tail match, then no-op and head removal
  task automatic test_delete_cases();
    send_item(fqdk_pkg::OP_DEL, 16'h1234, 16'h0000);
    send_item(fqdk_pkg::OP_DEL, 16'h0003, 16'h0000);
    send_item(fqdk_pkg::OP_DEL, 16'h8001, 16'hFFFF);
    send_item(OP_NONE, 16'h0000, 16'h0000);
    send_item(fqdk_pkg::OP_DEQ, 16'hFFFF, 16'h0000);
  endtask

  // Receiver holds off for a long stretch while items keep coming
  task automatic test_back_pressure();
    rx_hold_req = 1'b1;
    for (int i = 0; i < 24; i++) begin
      if (i % 4 == 3) send_item(fqdk_pkg::OP_DEL, pick_key(), fqdk_pkg::IN_QTY_W'($urandom));
      else            send_item(fqdk_pkg::OP_ENQ, pick_id(), fqdk_pkg::IN_QTY_W'($urandom));
    end
    wait_drained();
  endtask

  // Random mix in alternating fill and drain phases; the first stretch
  // runs with no idling, and the sender pauses once half way
  task automatic test_random_traffic(int n);
    int                        pick;
    bit                        filling;
    logic [fqdk_pkg::OP_W-1:0] op;
    for (int k = 0; k < n; k++) begin
      calm    = (k < 100);
      filling = ((k / 50) % 2) == 0;
      pick    = $urandom_range(0, 99);
      if (filling) begin
        op = (pick < 55) ? fqdk_pkg::OP_ENQ : (pick < 70) ? fqdk_pkg::OP_DEQ :
             (pick < 95) ? fqdk_pkg::OP_DEL : OP_NONE;
      end else begin
        op = (pick < 25) ? fqdk_pkg::OP_ENQ : (pick < 55) ? fqdk_pkg::OP_DEQ :
             (pick < 95) ? fqdk_pkg::OP_DEL : OP_NONE;
      end
      if (k == n / 2) wait_drained();
      send_item(op, (op == fqdk_pkg::OP_DEL) ? pick_key() : pick_id(),
                fqdk_pkg::IN_QTY_W'($urandom));
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_queue();
    test_fill_and_overflow();
    test_delete_cases();
    test_back_pressure();
    test_random_traffic(ITEMS_RANDOM);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d items, %0d results checked, peak fill %0d of %0d",
             items_sent, results_got, peak_fill, QUEUE_DEPTH);
    $display("status mix: done %0d, empty %0d, not found %0d, full %0d; %0d failures",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], failures);
    if (failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[sim.f]
design/fqdk_pkg.sv
design/fqdk_ctrl.sv
design/fqdk_dpath.sv
design/fifo_queue_with_delete_by_key_unit.sv
design/fqdk_checker.sv
tb/sv/tb.sv
